// File: hdl/radial_linear_fog_factor_macros.svh
// Assertion macros for the radial linear fog factor block.
// Included by the top level; no other dependencies.
`ifndef RADIAL_LINEAR_FOG_FACTOR_MACROS_SVH
`define RADIAL_LINEAR_FOG_FACTOR_MACROS_SVH
// implication checked on every clock unless in reset
`define RLFF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RLFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/rlff_pkg.sv
// Shared types and constants for the radial linear fog factor block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rlff_pkg;
   localparam int unsigned FRAC_BITS = 8;
   localparam logic [2:0] REG_EYE_X     = 3'd0;
   localparam logic [2:0] REG_EYE_Y     = 3'd1;
   localparam logic [2:0] REG_EYE_Z     = 3'd2;
   localparam logic [2:0] REG_FOG_START = 3'd3;
   localparam logic [2:0] REG_FOG_END   = 3'd4;
   localparam int unsigned CSR_INDEX_BITS = 3;

   // front-end classification carried to the back end
   typedef struct packed {
      logic before_start;  // m < 0
      logic beyond_end;    // m > span
      logic zero_span;     // span == 0
   } class_type;
endpackage
`default_nettype wire

// File: hdl/rlff_stream_if.sv
// Valid/ready stream interface with parameterized payload width.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rlff_stream_if #(parameter int unsigned WIDTH = 16);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/rlff_front.sv
// Front end: squared distance, pipelined square root, offset and classification.
// Depends on rlff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlff_front #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [COORD_BITS-1:0] pos_x,
   input  wire logic [COORD_BITS-1:0] pos_y,
   input  wire logic [COORD_BITS-1:0] pos_z,
   input  wire logic [COORD_BITS-1:0] eye_x,
   input  wire logic [COORD_BITS-1:0] eye_y,
   input  wire logic [COORD_BITS-1:0] eye_z,
   input  wire logic [COORD_BITS-1:0] fog_start,
   input  wire logic [COORD_BITS-1:0] fog_end,
   output logic                       out_valid,
   output logic [COORD_BITS+rlff_pkg::FRAC_BITS-1:0] m_out,
   output logic [COORD_BITS+rlff_pkg::FRAC_BITS-1:0] span_out,
   output rlff_pkg::class_type        cls_out
);
   localparam int unsigned DB = COORD_BITS + 1;           // diff magnitude bits
   localparam int unsigned SB = 2 * DB + 2;               // sum of squares bits
   localparam int unsigned RB = (SB + 1) / 2 + rlff_pkg::FRAC_BITS; // root bits
   localparam int unsigned NB = 2 * RB;                   // scaled radicand
   localparam int unsigned WB = COORD_BITS + rlff_pkg::FRAC_BITS + 1;
   localparam int unsigned PB = 2;                        // pre-root stages
   localparam int unsigned LAT = PB + RB;

   // stage 1: absolute differences
   logic [DB-1:0] ax_ff, ay_ff, az_ff;
   logic [DB:0]   dx, dy, dz;
   assign dx = {{2{pos_x[COORD_BITS-1]}}, pos_x} - {{2{eye_x[COORD_BITS-1]}}, eye_x};
   assign dy = {{2{pos_y[COORD_BITS-1]}}, pos_y} - {{2{eye_y[COORD_BITS-1]}}, eye_y};
   assign dz = {{2{pos_z[COORD_BITS-1]}}, pos_z} - {{2{eye_z[COORD_BITS-1]}}, eye_z};
   // stage 2: sum of squares
   logic [SB-1:0] d2_ff;
   logic [2*DB-1:0] sx, sy, sz;
   assign sx = ax_ff * ax_ff;
   assign sy = ay_ff * ay_ff;
   assign sz = az_ff * az_ff;

   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= dx[DB] ? DB'(-dx) : dx[DB-1:0];
         ay_ff <= dy[DB] ? DB'(-dy) : dy[DB-1:0];
         az_ff <= dz[DB] ? DB'(-dz) : dz[DB-1:0];
         d2_ff <= SB'(sx) + SB'(sy) + SB'(sz);
      end
   end

   // restoring square root, one result bit per stage
   logic [NB-1:0]   rad_ff  [RB];
   logic [RB+1:0]   rem_ff  [RB];
   logic [RB-1:0]   root_ff [RB];
   logic [COORD_BITS-1:0] st_ff [RB];
   logic [COORD_BITS-1:0] en_ff [RB];

   for (genvar k = 0; k < RB; k++) begin : g_root
      logic [NB-1:0] rad_i;
      logic [RB+1:0] rem_i;
      logic [RB-1:0] root_i;
      logic [COORD_BITS-1:0] st_i, en_i;
      logic [RB+1:0] cur, trial;
      if (k == 0) begin : g_first
         assign rad_i  = NB'(d2_ff) << (2 * rlff_pkg::FRAC_BITS);
         assign rem_i  = '0;
         assign root_i = '0;
         assign st_i   = fog_start;
         assign en_i   = fog_end;
      end else begin : g_next
         assign rad_i  = rad_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign st_i   = st_ff[k-1];
         assign en_i   = en_ff[k-1];
      end
      assign cur   = {rem_i[RB-1:0], rad_i[NB-1 -: 2]};
      assign trial = {root_i, 2'b01};
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k] <= rad_i << 2;
            st_ff[k]  <= st_i;
            en_ff[k]  <= en_i;
            if (cur >= trial) begin
               rem_ff[k]  <= cur - trial;
               root_ff[k] <= {root_i[RB-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= cur;
               root_ff[k] <= {root_i[RB-2:0], 1'b0};
            end
         end
      end
   end

   // offset and classification, combinational on the last root stage
   logic [RB+1:0] len_w, s_w, m_w;
   logic [WB:0]   sp_w;
   assign len_w = (RB+2)'(root_ff[RB-1]);
   assign s_w   = (RB+2)'({st_ff[RB-1], {rlff_pkg::FRAC_BITS{1'b0}}});
   assign m_w   = len_w - s_w;
   assign sp_w  = {1'b0, en_ff[RB-1], {rlff_pkg::FRAC_BITS{1'b0}}}
                - {1'b0, st_ff[RB-1], {rlff_pkg::FRAC_BITS{1'b0}}};

   assign out_valid = vld_ff[LAT-1];
   assign cls_out.before_start = len_w < s_w;
   assign cls_out.zero_span    = sp_w == '0;
   assign cls_out.beyond_end   = !(len_w < s_w)
      && (sp_w[WB] || (m_w > (RB+2)'(sp_w[WB-1:0])));
   // only read when 0 <= m <= span, so both fit WB-1 bits
   assign m_out    = m_w[WB-2:0];
   assign span_out = sp_w[WB-2:0];
endmodule
`default_nettype wire

// File: hdl/rlff_queue.sv
// Skid queue between front and back end, DEPTH words deep.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rlff_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);
   localparam int unsigned AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CB = $clog2(DEPTH + 1);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AB-1:0] wp_ff, rp_ff;
   logic [CB-1:0] cnt_ff;
   logic       push, pop;
   assign in_ready  = cnt_ff != CB'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AB'(DEPTH - 1)) ? '0 : wp_ff + AB'(1);
         if (pop) rp_ff <= (rp_ff == AB'(DEPTH - 1)) ? '0 : rp_ff + AB'(1);
         cnt_ff <= cnt_ff + CB'(push) - CB'(pop);
      end
   end
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

// File: hdl/rlff_divider.sv
// Back end: pipelined restoring divider forming m * full / span, with output register.
// Depends on rlff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlff_divider #(
   parameter int unsigned COORD_BITS = 16,
   parameter int unsigned ALPHA_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [COORD_BITS+rlff_pkg::FRAC_BITS-1:0] m_in,
   input  wire logic [COORD_BITS+rlff_pkg::FRAC_BITS-1:0] span_in,
   input  wire rlff_pkg::class_type   cls_in,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [ALPHA_BITS-1:0]      alpha
);
   localparam int unsigned WB = COORD_BITS + rlff_pkg::FRAC_BITS;
   localparam int unsigned QB = ALPHA_BITS;   // quotient bits (q <= full)
   localparam int unsigned NB = WB + ALPHA_BITS;
   localparam logic [ALPHA_BITS-1:0] FULL = '1;
   localparam logic [1:0] SEL_DIV  = 2'd0;
   localparam logic [1:0] SEL_ZERO = 2'd1;
   localparam logic [1:0] SEL_FULL = 2'd2;

   logic en;
   // stage 0: numerator m * full
   logic [NB-1:0] num_ff;
   logic [WB-1:0] den_ff [QB+1];
   logic [WB:0]   rem_ff [QB];
   logic [NB-1:0] nsh_ff [QB];
   logic [QB-1:0] q_ff   [QB];
   logic [1:0]    sel_ff [QB+1];
   logic [QB:0]   vld_ff;
   logic [ALPHA_BITS-1:0] out_ff;
   logic out_vld_ff;

   assign en = !out_vld_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[QB-1:0], in_valid};
         out_vld_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= NB'(m_in) * NB'(FULL);
         den_ff[0] <= span_in;
         if (cls_in.before_start) sel_ff[0] <= SEL_ZERO;
         else if (cls_in.beyond_end) sel_ff[0] <= SEL_FULL;
         else if (cls_in.zero_span) sel_ff[0] <= SEL_ZERO;
         else sel_ff[0] <= SEL_DIV;
      end
   end

   // quotient fits in QB bits, so the top WB+1 numerator bits start the division
   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [WB:0]   rem_i, cur;
      logic [NB-1:0] n_i;
      logic [QB-1:0] q_i;
      if (k == 0) begin : g_first
         assign rem_i = '0;
         assign n_i   = num_ff;
         assign q_i   = '0;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign n_i   = nsh_ff[k-1];
         assign q_i   = q_ff[k-1];
      end
      assign cur = (k == 0) ? n_i[NB-1 -: WB+1] : {rem_i[WB-1:0], n_i[NB-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1] <= den_ff[k];
            sel_ff[k+1] <= sel_ff[k];
            nsh_ff[k]   <= (k == 0) ? (n_i << (WB + 1)) : (n_i << 1);
            if (cur >= {1'b0, den_ff[k]}) begin
               rem_ff[k] <= cur - {1'b0, den_ff[k]};
               q_ff[k]   <= {q_i[QB-2:0], 1'b1};
            end else begin
               rem_ff[k] <= cur;
               q_ff[k]   <= {q_i[QB-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         case (sel_ff[QB])
            SEL_ZERO: out_ff <= '0;
            SEL_FULL: out_ff <= FULL;
            default:  out_ff <= q_ff[QB-1];
         endcase
      end
   end

   assign out_valid = out_vld_ff;
   assign alpha = out_ff;
endmodule
`default_nettype wire

// File: hdl/radial_linear_fog_factor.sv
// Top level of the radial linear fog factor block.
// Depends on rlff_pkg, rlff_stream_if, rlff_front, rlff_queue, rlff_divider and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "radial_linear_fog_factor_macros.svh"
// Radial linear fog: one vertex word per clock while queue credits remain. The front end takes the
// word when the skid queue has room, forms the squared eye distance, runs a
// fully pipelined square root (one root bit per stage) and classifies the offset;
// the back end runs a pipelined divider (one quotient bit per stage) into an
// output register. Configuration is sampled per stage, so write it only while the
// block is idle.
module radial_linear_fog_factor #(
   parameter int unsigned COORD_BITS = 16,
   parameter int unsigned ALPHA_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rlff_stream_if.sink   req,
   rlff_stream_if.source rsp,
   input  wire logic  csr_valid,
   output logic       csr_ready,
   input  wire logic [rlff_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0] csr_data
);
   localparam int unsigned WB = COORD_BITS + rlff_pkg::FRAC_BITS;
   localparam int unsigned QW = 2 * WB + 3;

   logic [COORD_BITS-1:0] eye_x_ff, eye_y_ff, eye_z_ff, start_ff, end_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff <= '0;
         eye_y_ff <= '0;
         eye_z_ff <= '0;
         start_ff <= COORD_BITS'(1);
         end_ff   <= COORD_BITS'(1500);
      end else if (csr_valid) begin
         unique case (csr_index)
            rlff_pkg::REG_EYE_X:     eye_x_ff <= csr_data;
            rlff_pkg::REG_EYE_Y:     eye_y_ff <= csr_data;
            rlff_pkg::REG_EYE_Z:     eye_z_ff <= csr_data;
            rlff_pkg::REG_FOG_START: start_ff <= csr_data;
            rlff_pkg::REG_FOG_END:   end_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // front pipeline never stalls; a credit counter keeps the queue from overflowing
   localparam int unsigned FLAT = 2 + (2 * COORD_BITS + 5) / 2 + rlff_pkg::FRAC_BITS;
   localparam int unsigned QD = FLAT + 2;
   localparam int unsigned CB = $clog2(QD + 1);
   logic f_valid, q_ready, q_valid, d_ready;
   logic [WB-1:0] f_m, f_span, q_m, q_span;
   rlff_pkg::class_type f_cls, q_cls;
   logic [QW-1:0] q_in, q_out;
   logic [CB-1:0] inflight_ff;
   logic req_acc, q_pop;

   // front never stalls; admission limited to free queue slots
   assign req.ready = inflight_ff < CB'(QD);
   assign req_acc = req.valid && req.ready;
   assign q_pop = q_valid && d_ready;
   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= '0;
      else inflight_ff <= inflight_ff + CB'(req_acc) - CB'(q_pop);
   end

   rlff_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .en(1'b1), .in_valid(req_acc),
      .pos_x(req.data[COORD_BITS-1:0]),
      .pos_y(req.data[2*COORD_BITS-1:COORD_BITS]),
      .pos_z(req.data[3*COORD_BITS-1:2*COORD_BITS]),
      .eye_x(eye_x_ff), .eye_y(eye_y_ff), .eye_z(eye_z_ff),
      .fog_start(start_ff), .fog_end(end_ff),
      .out_valid(f_valid), .m_out(f_m), .span_out(f_span), .cls_out(f_cls)
   );

   assign q_in = {f_cls, f_span, f_m};
   rlff_queue #(.WIDTH(QW), .DEPTH(QD)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(q_ready), .in_data(q_in),
      .out_valid(q_valid), .out_ready(d_ready), .out_data(q_out)
   );
   assign q_m    = q_out[WB-1:0];
   assign q_span = q_out[2*WB-1:WB];
   assign q_cls  = q_out[QW-1:2*WB];

   rlff_divider #(.COORD_BITS(COORD_BITS), .ALPHA_BITS(ALPHA_BITS)) u_div (
      .clock, .reset, .in_valid(q_valid), .in_ready(d_ready),
      .m_in(q_m), .span_in(q_span), .cls_in(q_cls),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .alpha(rsp.data)
   );

   `RLFF_ASSERT_IMPL(a_queue_room, clock, reset, f_valid, q_ready, "queue overflow")
   `RLFF_ASSERT_IMPL(a_credit_max, clock, reset, 1'b1, inflight_ff <= CB'(QD), "credit overrun")
   `RLFF_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data), "result dropped")
endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking bench for radial_linear_fog_factor: streams vertex words over several
// fog set-ups and compares every fog alpha with a built-in fixed-point predictor.
// Depends on rlff_pkg, rlff_stream_if and the block itself.
`timescale 1ns / 1ps
module tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rlff_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   rlff_stream_if #(.WIDTH(48)) req_if ();
   rlff_stream_if #(.WIDTH(16)) rsp_if ();

   radial_linear_fog_factor i_dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic signed [15:0] eye_x = 0, eye_y = 0, eye_z = 0;
   logic [15:0] fog_start = 16'd1, fog_end = 16'd1500;

   logic [47:0] vertex_q[$];
   logic [15:0] alpha_q[$];
   int errors = 0;
   int send_gap = 0, recv_gap = 0, long_hold = 0;
   bit req_taken = 0, rsp_taken = 0;

   function automatic longint unsigned root_q8(longint unsigned n);
      longint unsigned rem = 0, root = 0, pair, trial;
      for (int i = 31; i >= -8; i--) begin
         pair = (i >= 0) ? ((n >> (2 * i)) & 64'd3) : 64'd0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic [15:0] fog_alpha_of(logic [47:0] v);
      longint dx, dy, dz, len, s, span, m;
      dx = longint'($signed(v[15:0])) - longint'(eye_x);
      dy = longint'($signed(v[31:16])) - longint'(eye_y);
      dz = longint'($signed(v[47:32])) - longint'(eye_z);
      len = longint'(root_q8(longint'(dx * dx + dy * dy + dz * dz)));
      s = longint'(fog_start) << 8;
      span = (longint'(fog_end) - longint'(fog_start)) * 256;
      m = len - s;
      if (m < 0) return 16'd0;
      if (m > span) return 16'hffff;
      if (span == 0) return 16'd0;
      return 16'((longint'(m) * 65535) / span);
   endfunction

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("error: %s got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) alpha_q.push_back(fog_alpha_of(req_if.data));
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (req_taken) send_gap = $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
         if (send_gap > 0 || vertex_q.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid <= 1'b1;
            req_if.data <= vertex_q.pop_front();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_taken <= rsp_if.valid && rsp_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
         if (alpha_q.size() == 0) report("unexpected word", rsp_if.data, 16'd0);
         else if (rsp_if.data !== alpha_q[0]) report("fog_alpha", rsp_if.data, alpha_q.pop_front());
         else void'(alpha_q.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) recv_gap = $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [rlff_pkg::CSR_INDEX_BITS-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rlff_pkg::REG_EYE_X: eye_x = val;
         rlff_pkg::REG_EYE_Y: eye_y = val;
         rlff_pkg::REG_EYE_Z: eye_z = val;
         rlff_pkg::REG_FOG_START: fog_start = val;
         rlff_pkg::REG_FOG_END: fog_end = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_fog(logic [15:0] ex, logic [15:0] ey, logic [15:0] ez,
                          logic [15:0] st, logic [15:0] en);
      csr_write(rlff_pkg::REG_EYE_X, ex);
      csr_write(rlff_pkg::REG_EYE_Y, ey);
      csr_write(rlff_pkg::REG_EYE_Z, ez);
      csr_write(rlff_pkg::REG_FOG_START, st);
      csr_write(rlff_pkg::REG_FOG_END, en);
      csr_write(3'($urandom_range(5, 7)), 16'($urandom));
   endtask

   task automatic push_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      vertex_q.push_back({z, y, x});
   endtask

   task automatic push_random(int n);
      int r, reach;
      for (int k = 0; k < n; k++) begin
         reach = (fog_end > fog_start ? int'(fog_end) : int'(fog_start)) + 64;
         if ($urandom_range(0, 3) == 0) begin
            push_vertex(16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            r = reach * 2 / 3;
            push_vertex(16'(eye_x + $signed($urandom_range(0, 2 * r)) - r),
                        16'(eye_y + $signed($urandom_range(0, 2 * r)) - r),
                        16'(eye_z + $signed($urandom_range(0, 2 * r)) - r));
         end
      end
   endtask

   task automatic drain();
      while (vertex_q.size() != 0 || alpha_q.size() != 0 || req_if.valid) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset set-up: extremes, origin, inside the range
      push_vertex(16'h0000, 16'h0000, 16'h0000);
      push_vertex(16'h8000, 16'h8000, 16'h8000);
      push_vertex(16'h7fff, 16'h7fff, 16'h7fff);
      push_vertex(16'h8000, 16'h7fff, 16'h0000);
      push_vertex(16'd1, 16'd0, 16'd0);
      push_vertex(16'd750, 16'd0, 16'd0);
      push_vertex(16'd1500, 16'd0, 16'd0);
      push_vertex(16'd1501, 16'd0, 16'd0);
      push_vertex(16'd500, 16'd500, 16'd500);
      push_random(250);
      drain();

      // zero span at start, end below start
      set_fog(16'd0, 16'd0, 16'd0, 16'd100, 16'd100);
      push_vertex(16'd100, 16'd0, 16'd0);
      push_vertex(16'd0, 16'hff9c, 16'd0);
      push_vertex(16'd99, 16'd0, 16'd0);
      push_vertex(16'd101, 16'd0, 16'd0);
      push_random(150);
      drain();
      set_fog(16'd10, 16'hfff6, 16'd3, 16'd2000, 16'd500);
      push_random(150);
      drain();

      // extreme eye and full fog range; long receiver stall
      set_fog(16'h8000, 16'h7fff, 16'h8000, 16'd0, 16'hffff);
      push_vertex(16'h7fff, 16'h8000, 16'h7fff);
      push_vertex(16'h8000, 16'h7fff, 16'h8000);
      long_hold = 300;
      push_random(300);
      drain();
      set_fog(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
      push_random(100);
      drain();
      set_fog(16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'd0);
      push_random(100);
      drain();

      for (int p = 0; p < 5; p++) begin
         set_fog(16'($urandom_range(0, 4000) - 2000), 16'($urandom),
                 16'($urandom_range(0, 200)), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 6000)));
         push_random(160);
         drain();
      end

      if (errors == 0) $display("radial_linear_fog_factor: match");
      else $display("radial_linear_fog_factor: mismatch");
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("radial_linear_fog_factor: mismatch");
      $finish;
   end
endmodule
